### hdl/mwm_pkg.sv
// Shared types, constants and register codes for the mecanum wheel mixer.
`default_nettype none
package mwm_pkg;
	localparam int CfgIdxW = 3;
	localparam int QueueDepthDef = 4;

	typedef enum logic [CfgIdxW-1:0] {
		REG_LIMIT_SIDEWAYS = 3'd0,
		REG_LIMIT_FORWARD  = 3'd1,
		REG_LIMIT_ROTATION = 3'd2,
		REG_ROTATE_GAIN    = 3'd3,
		REG_RPM_GAIN       = 3'd4,
		REG_WHEEL_LIMIT    = 3'd5
	} reg_idx_t;

	localparam logic [14:0] RstLimitSideways = 15'd3000;
	localparam logic [14:0] RstLimitForward  = 15'd3000;
	localparam logic [14:0] RstLimitRotation = 15'd300;
	localparam logic [15:0] RstRotateGain    = 16'd1787;
	localparam logic [15:0] RstRpmGain       = 16'd433;
	localparam logic [14:0] RstWheelLimit    = 15'd8500;

	// one mixed command waiting for the limiter
	typedef struct packed {
		logic signed [3:0][15:0] wheel;
		logic [15:0]             maxabs;
		logic [14:0]             limit;
	} mix_item_t;

	// divider control word travelling with each lane
	typedef struct packed {
		logic        scale;
		logic        neg;
		logic [15:0] divisor;
	} div_ctl_t;
endpackage
`default_nettype wire

### hdl/mwm_front.sv
// Front: clamps a command and mixes it into four saturated wheel speeds, with max magnitude.
`default_nettype none
module mwm_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic signed [15:0]  speed_sideways,
	input  wire logic signed [15:0]  speed_forward,
	input  wire logic signed [15:0]  speed_rotation,
	input  wire logic [14:0]         limit_sideways,
	input  wire logic [14:0]         limit_forward,
	input  wire logic [14:0]         limit_rotation,
	input  wire logic [15:0]         rotate_gain,
	input  wire logic [15:0]         rpm_gain,
	input  wire logic [14:0]         wheel_rpm_limit,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output mwm_pkg::mix_item_t       out_item
);
	import mwm_pkg::*;

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [15:0] vx_s1, vy_s1, vw_s1;
	logic signed [17:0] lin_s2 [4];
	logic signed [32:0] rot_s2;
	logic signed [33:0] q8_s3 [4];
	logic signed [50:0] q24_s4 [4];
	logic [14:0] lim_s1, lim_s2, lim_s3, lim_s4;
	logic [15:0] rg_s2;
	logic signed [15:0] wheel_c [4];
	logic [15:0] abs_c [4];
	logic [15:0] m01, m23;

	// whole pipe stalls together when its last stage cannot leave
	assign adv = !v_s4 || out_ready;
	assign in_ready = adv;
	assign out_valid = v_s4;

	function automatic logic signed [15:0] clampv(input logic signed [15:0] v,
			input logic [14:0] l);
		logic signed [16:0] ls;
		ls = {2'b00, l};
		if ($signed({v[15], v}) > ls) return {1'b0, l};
		else if ($signed({v[15], v}) < -ls) return 16'(-ls);
		else return v;
	endfunction

	function automatic logic signed [15:0] to_i16(input logic signed [50:0] v);
		logic [50:0] mag;
		logic [26:0] ip;
		mag = v[50] ? 51'(-v) : v;
		ip = mag[50:24];
		if (v[50]) return (ip > 27'd32768) ? 16'sh8000 : 16'(-{1'b0, ip[15:0]});
		else return (ip > 27'd32767) ? 16'sh7fff : 16'(ip);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vx_s1 <= clampv(speed_sideways, limit_sideways);
			vy_s1 <= clampv(speed_forward, limit_forward);
			vw_s1 <= clampv(speed_rotation, limit_rotation);
			lim_s1 <= wheel_rpm_limit;
			lin_s2[0] <= -18'(vx_s1) - 18'(vy_s1);
			lin_s2[1] <= 18'(vx_s1) - 18'(vy_s1);
			lin_s2[2] <= 18'(vx_s1) + 18'(vy_s1);
			lin_s2[3] <= -18'(vx_s1) + 18'(vy_s1);
			rot_s2 <= 33'(vw_s1) * $signed({17'd0, rotate_gain});
			rg_s2 <= rpm_gain;
			lim_s2 <= lim_s1;
			for (int i = 0; i < 4; i++) begin
				q8_s3[i] <= 34'(lin_s2[i]) * 34'sd256 + 34'(rot_s2);
				q24_s4[i] <= 51'(q8_s3[i]) * $signed({35'd0, rg_s2});
			end
			lim_s3 <= lim_s2;
			lim_s4 <= lim_s3;
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			wheel_c[i] = to_i16(q24_s4[i]);
			abs_c[i] = wheel_c[i][15] ? 16'(-wheel_c[i]) : wheel_c[i];
			out_item.wheel[i] = wheel_c[i];
		end
		m01 = (abs_c[0] > abs_c[1]) ? abs_c[0] : abs_c[1];
		m23 = (abs_c[2] > abs_c[3]) ? abs_c[2] : abs_c[3];
		out_item.maxabs = (m01 > m23) ? m01 : m23;
		out_item.limit = lim_s4;
	end
endmodule
`default_nettype wire

### hdl/mwm_queue.sv
// Short queue between the mixer front and the limiter back.
`default_nettype none
module mwm_queue #(
	parameter int Depth = mwm_pkg::QueueDepthDef
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_valid,
	output logic               wr_ready,
	input  wire mwm_pkg::mix_item_t wr_item,
	output logic               rd_valid,
	input  wire logic          rd_ready,
	output mwm_pkg::mix_item_t rd_item
);
	import mwm_pkg::*;
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

	mix_item_t mem_q [Depth];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != (AW+1)'(Depth);
	assign rd_valid = cnt_q != '0;
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	assign rd_item = mem_q[rp_q];

	function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
		return (p == AW'(Depth - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= nxt(wp_q);
			if (rd) rp_q <= nxt(rp_q);
			if (wr && !rd) cnt_q <= cnt_q + 1'b1;
			else if (rd && !wr) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_item;
	end
endmodule
`default_nettype wire

### hdl/mwm_back.sv
// Back: proportional limiting by a pipelined restoring divider, one quotient bit a stage.
`default_nettype none
module mwm_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire mwm_pkg::mix_item_t in_item,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [15:0]      rpm_front_right,
	output logic signed [15:0]      rpm_back_right,
	output logic signed [15:0]      rpm_back_left,
	output logic signed [15:0]      rpm_front_left,
	output logic                    was_scaled
);
	import mwm_pkg::*;
	localparam int NB = 31; // bits of |wheel|*limit

	logic adv;
	logic v_s1;
	logic [NB:0] v_st;
	logic signed [15:0] w_s1 [4];
	logic [15:0] m_s1;
	logic [14:0] l_s1;
	logic [NB-1:0] num_st [NB+1][4];
	logic [15:0]   rem_st [NB+1][4];
	div_ctl_t      ctl_st [NB+1][4];
	logic signed [15:0] wheel_st [NB+1][4];
	logic signed [15:0] res_c [4];
	logic [16:0] trial [NB][4];

	assign adv = !v_st[NB] || out_ready;
	assign in_ready = adv;
	assign out_valid = v_st[NB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_st <= '0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_st <= {v_st[NB-1:0], v_s1};
		end
	end

	// stage 1: register item; stage 2: form |wheel|*limit; then one bit per stage
	always_ff @(posedge clk) begin
		if (adv) begin
			w_s1 <= '{in_item.wheel[0], in_item.wheel[1], in_item.wheel[2], in_item.wheel[3]};
			m_s1 <= in_item.maxabs;
			l_s1 <= in_item.limit;
			for (int i = 0; i < 4; i++) begin
				num_st[0][i] <= NB'((w_s1[i][15] ? 17'(-17'(w_s1[i])) : 17'(w_s1[i])))
					* NB'(l_s1);
				rem_st[0][i] <= '0;
				ctl_st[0][i].scale <= m_s1 > {1'b0, l_s1};
				ctl_st[0][i].neg <= w_s1[i][15];
				ctl_st[0][i].divisor <= m_s1;
				wheel_st[0][i] <= w_s1[i];
				for (int k = 0; k < NB; k++) begin
					num_st[k+1][i] <= {num_st[k][i][NB-2:0],
						trial[k][i] >= {1'b0, ctl_st[k][i].divisor}};
					rem_st[k+1][i] <= (trial[k][i] >= {1'b0, ctl_st[k][i].divisor})
						? 16'(trial[k][i] - {1'b0, ctl_st[k][i].divisor})
						: trial[k][i][15:0];
					ctl_st[k+1][i] <= ctl_st[k][i];
					wheel_st[k+1][i] <= wheel_st[k][i];
				end
			end
		end
	end

	always_comb begin
		for (int k = 0; k < NB; k++)
			for (int i = 0; i < 4; i++)
				trial[k][i] = {rem_st[k][i], num_st[k][i][NB-1]};
		for (int i = 0; i < 4; i++) begin
			if (ctl_st[NB][i].scale)
				res_c[i] = ctl_st[NB][i].neg ? 16'(-num_st[NB][i][15:0])
					: num_st[NB][i][15:0];
			else
				res_c[i] = wheel_st[NB][i];
		end
	end

	assign rpm_front_right = res_c[0];
	assign rpm_back_right  = res_c[1];
	assign rpm_back_left   = res_c[2];
	assign rpm_front_left  = res_c[3];
	assign was_scaled      = ctl_st[NB][0].scale;
endmodule
`default_nettype wire

### hdl/mecanum_wheel_mixer_top.sv
// Top level of the mecanum wheel mixer: registers, front mixer, queue, limiter back.
//
//  channel   handshake              payload
//  command   push / full            speed_sideways, speed_forward, speed_rotation
//  result    pop / empty            rpm_front_right .. rpm_front_left, was_scaled
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One command is accepted per cycle while full is low; each takes 4 front stages, one queue
// slot, then 33 back stages (item register, product, 31 divider steps).
// Reset loads the register defaults and empties every stage and the queue.
// A stall on pop backs up the back pipe, then the queue, then raises full.
`default_nettype none
module mecanum_wheel_mixer_top #(
	parameter int QueueDepth = mwm_pkg::QueueDepthDef
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	output logic                              full,
	input  wire logic signed [15:0]           speed_sideways,
	input  wire logic signed [15:0]           speed_forward,
	input  wire logic signed [15:0]           speed_rotation,
	output logic                              empty,
	input  wire logic                         pop,
	output logic signed [15:0]                rpm_front_right,
	output logic signed [15:0]                rpm_back_right,
	output logic signed [15:0]                rpm_back_left,
	output logic signed [15:0]                rpm_front_left,
	output logic                              was_scaled,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [mwm_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [15:0]                  cfg_data
);
	import mwm_pkg::*;

	logic [14:0] lim_sw_q, lim_fw_q, lim_rot_q, wlim_q;
	logic [15:0] rot_gain_q, rpm_gain_q;
	logic f_ready, f_valid, q_ready, q_valid, b_ready, b_valid;
	mix_item_t f_item, q_item;

	assign cfg_ready = 1'b1;
	assign full = !f_ready;
	assign empty = !b_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_sw_q <= RstLimitSideways;
			lim_fw_q <= RstLimitForward;
			lim_rot_q <= RstLimitRotation;
			rot_gain_q <= RstRotateGain;
			rpm_gain_q <= RstRpmGain;
			wlim_q <= RstWheelLimit;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_LIMIT_SIDEWAYS: lim_sw_q <= cfg_data[14:0];
				REG_LIMIT_FORWARD:  lim_fw_q <= cfg_data[14:0];
				REG_LIMIT_ROTATION: lim_rot_q <= cfg_data[14:0];
				REG_ROTATE_GAIN:    rot_gain_q <= cfg_data;
				REG_RPM_GAIN:       rpm_gain_q <= cfg_data;
				REG_WHEEL_LIMIT:    wlim_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	mwm_front u_front (
		.clk, .arst_n,
		.in_valid(push), .in_ready(f_ready),
		.speed_sideways, .speed_forward, .speed_rotation,
		.limit_sideways(lim_sw_q), .limit_forward(lim_fw_q),
		.limit_rotation(lim_rot_q), .rotate_gain(rot_gain_q),
		.rpm_gain(rpm_gain_q), .wheel_rpm_limit(wlim_q),
		.out_valid(f_valid), .out_ready(q_ready), .out_item(f_item)
	);

	mwm_queue #(.Depth(QueueDepth)) u_queue (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_ready(q_ready), .wr_item(f_item),
		.rd_valid(q_valid), .rd_ready(b_ready), .rd_item(q_item)
	);

	mwm_back u_back (
		.clk, .arst_n,
		.in_valid(q_valid), .in_ready(b_ready), .in_item(q_item),
		.out_valid(b_valid), .out_ready(pop),
		.rpm_front_right, .rpm_back_right, .rpm_back_left, .rpm_front_left,
		.was_scaled
	);
endmodule
`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the mecanum wheel mixer: wheel speed prediction and checks.
`timescale 1ns / 1ps
module tb_top;
	import mwm_pkg::*;

	typedef struct {
		logic signed [15:0] fr, br, bl, fl;
		logic               scaled;
	} wheel_set_t;

	// register copies used by the wheel predictor
	logic [14:0] lim_side, lim_fwd, lim_rot, lim_wheel;
	logic [15:0] gain_rot, gain_rpm;

	function automatic int clamp_speed(int v, int lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	function automatic int q24_to_rpm(longint v);
		longint mag;
		mag = (v < 0) ? -v : v;
		mag = mag >>> 24;
		if (v < 0) return (mag > 32768) ? -32768 : -int'(mag);
		return (mag > 32767) ? 32767 : int'(mag);
	endfunction

	function automatic wheel_set_t mix_wheels(logic signed [15:0] sx, logic signed [15:0] sy,
			logic signed [15:0] sw);
		int vx, vy, vw, maxabs, a;
		int lin[4];
		int w[4];
		longint rot;
		wheel_set_t r;
		vx = clamp_speed(sx, lim_side);
		vy = clamp_speed(sy, lim_fwd);
		vw = clamp_speed(sw, lim_rot);
		rot = longint'(vw) * longint'(gain_rot);
		lin[0] = -vx - vy; lin[1] = vx - vy; lin[2] = vx + vy; lin[3] = -vx + vy;
		maxabs = 0;
		for (int i = 0; i < 4; i++) begin
			w[i] = q24_to_rpm((longint'(lin[i]) * 256 + rot) * longint'(gain_rpm));
			a = (w[i] < 0) ? -w[i] : w[i];
			if (a > maxabs) maxabs = a;
		end
		r.scaled = maxabs > int'(lim_wheel);
		if (r.scaled)
			for (int i = 0; i < 4; i++)
				w[i] = int'((longint'(w[i]) * longint'(lim_wheel)) / longint'(maxabs));
		r.fr = 16'(w[0]); r.br = 16'(w[1]); r.bl = 16'(w[2]); r.fl = 16'(w[3]);
		return r;
	endfunction

	int errors = 0;

	task automatic report_mismatch(string what, int got, int want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
		errors++;
	endtask

	class wheel_scoreboard;
		wheel_set_t pending[$];

		function void note_command(logic signed [15:0] sx, logic signed [15:0] sy,
				logic signed [15:0] sw);
			pending.push_back(mix_wheels(sx, sy, sw));
		endfunction

		task check_result(wheel_set_t got);
			wheel_set_t e;
			if (pending.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
				return;
			end
			e = pending.pop_front();
			if (got.fr !== e.fr) report_mismatch("rpm_front_right", got.fr, e.fr);
			if (got.br !== e.br) report_mismatch("rpm_back_right", got.br, e.br);
			if (got.bl !== e.bl) report_mismatch("rpm_back_left", got.bl, e.bl);
			if (got.fl !== e.fl) report_mismatch("rpm_front_left", got.fl, e.fl);
			if (got.scaled !== e.scaled) report_mismatch("was_scaled", got.scaled, e.scaled);
		endtask
	endclass

	logic clk = 0, arst_n = 0;
	logic push = 0, pop = 0, cfg_valid = 0;
	logic signed [15:0] speed_sideways = 0, speed_forward = 0, speed_rotation = 0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [15:0] cfg_data = 0;
	logic full, empty, cfg_ready, was_scaled;
	logic signed [15:0] rpm_front_right, rpm_back_right, rpm_back_left, rpm_front_left;

	mecanum_wheel_mixer_top dut (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	wheel_scoreboard sb = new();
	int  transfers = 0;
	bit  calm = 0;
	bit  hold_off = 0;

	// result side: random stall bursts, plus a long hold-off when asked
	initial begin
		int gap;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				pop <= 0;
				repeat (300) @(negedge clk);
				hold_off = 0;
			end
			if (!calm && $urandom_range(0, 7) == 0) begin
				pop <= 0;
				gap = $urandom_range(1, 15);
				repeat (gap - 1) @(negedge clk);
			end else
				pop <= 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			wheel_set_t g;
			g.fr = rpm_front_right; g.br = rpm_back_right;
			g.bl = rpm_back_left; g.fl = rpm_front_left; g.scaled = was_scaled;
			sb.check_result(g);
			transfers++;
		end
		if (arst_n && push && !full) transfers++;
	end

	// watchdog: cycles with no transfer of any kind
	initial begin
		int idle, last;
		idle = 0; last = 0;
		forever begin
			@(posedge clk);
			if (transfers != last) idle = 0; else idle++;
			last = transfers;
			if (idle > 5000) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	task automatic send_command(logic signed [15:0] sx, logic signed [15:0] sy,
			logic signed [15:0] sw);
		int gap;
		if (!calm && $urandom_range(0, 7) == 0) begin
			push <= 0;
			gap = $urandom_range(1, 15);
			repeat (gap) @(negedge clk);
		end
		push <= 1;
		speed_sideways <= sx; speed_forward <= sy; speed_rotation <= sw;
		do @(posedge clk); while (full);
		sb.note_command(sx, sy, sw);
		@(negedge clk);
	endtask

	task automatic drain;
		push <= 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [15:0] value);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_LIMIT_SIDEWAYS: lim_side = value[14:0];
			REG_LIMIT_FORWARD:  lim_fwd = value[14:0];
			REG_LIMIT_ROTATION: lim_rot = value[14:0];
			REG_ROTATE_GAIN:    gain_rot = value;
			REG_RPM_GAIN:       gain_rpm = value;
			REG_WHEEL_LIMIT:    lim_wheel = value[14:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 0;
		@(negedge clk);
	endtask

	function automatic logic signed [15:0] rand_speed();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'($urandom_range(0, 8) - 4);
			3: return 16'($urandom_range(0, 8000) - 4000);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_phase(int n);
		repeat (n) send_command(rand_speed(), rand_speed(), rand_speed());
		drain();
	endtask

	initial begin
		logic signed [15:0] edge_vals[5];
		edge_vals = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh0001};
		lim_side = RstLimitSideways; lim_fwd = RstLimitForward; lim_rot = RstLimitRotation;
		gain_rot = RstRotateGain; gain_rpm = RstRpmGain; lim_wheel = RstWheelLimit;
		repeat (11) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: field extremes at reset settings
		for (int i = 0; i < 5; i++) begin
			send_command(edge_vals[i], 0, 0);
			send_command(0, edge_vals[i], 0);
			send_command(0, 0, edge_vals[i]);
		end
		send_command(2999, -3001, 301);
		send_command(-32768, -32768, -32768);
		send_command(32767, 32767, 32767);
		drain();

		// zero limits clamp everything; then full-range limits and gains; zero wheel limit forces scaling
		write_reg(REG_LIMIT_SIDEWAYS, 0);
		write_reg(REG_LIMIT_FORWARD, 0);
		write_reg(REG_LIMIT_ROTATION, 0);
		write_reg(REG_WHEEL_LIMIT, 1);
		send_command(1000, -1000, 100);
		drain();
		write_reg(REG_LIMIT_SIDEWAYS, 16'hFFFF);
		write_reg(REG_LIMIT_FORWARD, 16'h7FFF);
		write_reg(REG_LIMIT_ROTATION, 16'h7FFF);
		write_reg(REG_ROTATE_GAIN, 16'hFFFF);
		write_reg(REG_RPM_GAIN, 16'hFFFF);
		write_reg(REG_WHEEL_LIMIT, 16'hFFFF);
		send_command(-32768, 32767, -32768);
		send_command(32767, -32768, 32767);
		drain();
		write_reg(REG_WHEEL_LIMIT, 0);
		send_command(5, 7, 1);
		send_command(0, 0, 0);
		drain();

		// random phases across several settings
		write_reg(REG_LIMIT_SIDEWAYS, 16'(RstLimitSideways));
		write_reg(REG_LIMIT_FORWARD, 16'(RstLimitForward));
		write_reg(REG_LIMIT_ROTATION, 16'(RstLimitRotation));
		write_reg(REG_ROTATE_GAIN, RstRotateGain);
		write_reg(REG_RPM_GAIN, RstRpmGain);
		write_reg(REG_WHEEL_LIMIT, 16'(RstWheelLimit));
		random_phase(120);

		// fill the block while the receiver holds off
		hold_off = 1;
		random_phase(60);

		for (int p = 0; p < 4; p++) begin
			write_reg(REG_LIMIT_SIDEWAYS, 16'($urandom));
			write_reg(REG_LIMIT_FORWARD, 16'($urandom));
			write_reg(REG_LIMIT_ROTATION, 16'($urandom));
			write_reg(REG_ROTATE_GAIN, 16'($urandom));
			write_reg(REG_RPM_GAIN, 16'($urandom));
			write_reg(REG_WHEEL_LIMIT, 16'($urandom_range(1, 32767)));
			random_phase(80);
		end

		calm = 1;
		random_phase(130);

		if (errors == 0 && sb.pending.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
